// File: src/gfe_pkg.sv
// Shared types, register indexes and control structs for the 9x9 Gaussian filter.
package gfe_pkg;

  // Input item: source pixel or drain tick.
  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel_in;
  } gfe_in_t;

  // Result item: one filtered pixel with its position.
  typedef struct packed {
    logic [7:0] pixel_out;
    logic [9:0] out_col;
    logic [9:0] out_row;
    logic       frame_last;
  } gfe_out_t;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_D0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_D1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_D2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_D3  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_D4  = 3'd6;

  localparam int NUM_WREG = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FLUSH,
    ST_DIV,
    ST_DONE
  } gfe_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic emit;
  } gfe_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ready_emit;
    logic scan_last;
    logic pipe_busy;
    logic div_last;
  } gfe_status_t;

endpackage

// File: src/gfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/gfe_ctrl.sv
// Controller state machine: accept, check, window scan, pipeline flush, divide, hand off.
module gfe_ctrl
  import gfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  gfe_status_t status,
  input  logic        out_free,
  output gfe_cmd_t    cmd
);

  gfe_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.ready_emit ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!status.pipe_busy) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_CHECK: cmd.scan_start = status.ready_emit;
      ST_SCAN:  cmd.scan_step  = 1'b1;
      ST_FLUSH: cmd.div_start  = !status.pipe_busy;
      ST_DIV:   cmd.div_step   = 1'b1;
      ST_DONE:  cmd.emit       = out_free;
      default:  cmd            = '0;
    endcase
  end

endmodule

// File: src/gfe_dp.sv
// Datapath: position counters, line store, window accumulation and divider.
module gfe_dp
  import gfe_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int RADIUS      = 4,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  gfe_cmd_t                             cmd,
  input  gfe_in_t                              in_data,
  input  logic                                 restart,
  input  logic [$clog2(MAX_WIDTH)-1:0]         w_last,
  input  logic [$clog2(MAX_HEIGHT)-1:0]        h_last,
  input  logic [RADIUS:0][WEIGHT_BITS-1:0]     weights,
  output gfe_status_t                          status,
  output gfe_out_t                             result
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int LINES  = 2 * RADIUS + 2;
  localparam int SLOT_W = $clog2(LINES);
  localparam int TAPS   = 2 * RADIUS + 1;
  localparam int TAP_W  = $clog2(TAPS);
  localparam int DW     = $clog2(RADIUS + 1) > 0 ? $clog2(RADIUS + 1) : 1;
  localparam int DEPTH  = LINES << COL_W;
  localparam int AW     = $clog2(DEPTH);
  localparam int WP_W   = 2 * WEIGHT_BITS;
  localparam int SUM_G  = $clog2(TAPS * TAPS);
  localparam int WS_W   = WP_W + SUM_G;
  localparam int ACC_W  = 8 + WP_W + SUM_G;

  localparam logic [ROW_W:0]    R_ROW  = (ROW_W + 1)'(RADIUS);
  localparam logic [COL_W:0]    R_COL  = (COL_W + 1)'(RADIUS);
  localparam logic [TAP_W-1:0]  R_TAP  = TAP_W'(RADIUS);
  localparam logic [TAP_W-1:0]  T_LAST = TAP_W'(TAPS - 1);
  localparam logic [SLOT_W-1:0] S_LAST = SLOT_W'(LINES - 1);
  localparam logic [SLOT_W+1:0] R_SL   = (SLOT_W + 2)'(RADIUS);
  localparam logic [SLOT_W+1:0] L_SL   = (SLOT_W + 2)'(LINES);

  // Input and output positions.
  logic [COL_W-1:0]  in_col, ec;
  logic [ROW_W-1:0]  in_row, er;
  logic [SLOT_W-1:0] in_slot, er_slot;
  logic              in_done;

  // Window scan.
  logic [TAP_W-1:0]  ty, tx;
  logic              a_v, b_v, a_ok;
  logic [WP_W-1:0]   a_wprod;
  logic [WP_W+7:0]   b_prod;
  logic [WS_W-1:0]   wsum;
  logic [ACC_W-1:0]  acc;

  // Divider.
  logic [ACC_W-1:0]  rem;
  logic [2:0]        dk;
  logic [7:0]        quo;

  logic [7:0]        rdata;
  logic              ram_we;
  logic [AW-1:0]     waddr, raddr;

  logic              pixel_acc;
  assign pixel_acc = cmd.accept && (in_data.cmd == CMD_PIXEL);
  assign ram_we    = pixel_acc;
  assign waddr     = AW'({in_slot, in_col});

  gfe_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_data.pixel_in),
    .re    (cmd.scan_step),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Emission check: last needed neighbor has already arrived.
  logic [ROW_W:0]   nr_ext;
  logic [COL_W:0]   nc_ext;
  logic [ROW_W-1:0] nr;
  logic [COL_W-1:0] nc;
  logic             ready_emit;
  always_comb begin
    nr_ext = {1'b0, er} + R_ROW;
    nc_ext = {1'b0, ec} + R_COL;
    nr = (nr_ext > {1'b0, h_last}) ? h_last : nr_ext[ROW_W-1:0];
    nc = (nc_ext > {1'b0, w_last}) ? w_last : nc_ext[COL_W-1:0];
    ready_emit = in_done || (nr < in_row) || ((nr == in_row) && (nc < in_col));
  end

  assign status.ready_emit = ready_emit;

  // Tap address, bounds and weight.
  logic [ROW_W:0]     rs;
  logic [COL_W:0]     cs, cc;
  logic               row_ok, col_ok;
  logic [SLOT_W+1:0]  st, su;
  logic [TAP_W-1:0]   dy_abs, dx_abs;
  logic [WEIGHT_BITS-1:0] wy, wx;
  always_comb begin
    rs     = {1'b0, er} + (ROW_W + 1)'(ty);
    cs     = {1'b0, ec} + (COL_W + 1)'(tx);
    row_ok = (rs >= R_ROW) && ((rs - R_ROW) <= {1'b0, h_last});
    col_ok = (cs >= R_COL) && ((cs - R_COL) <= {1'b0, w_last});
    cc     = cs - R_COL;
    st     = (SLOT_W + 2)'(er_slot) + (SLOT_W + 2)'(ty);
    if (st >= R_SL) begin
      su = st - R_SL;
      if (su >= L_SL) su = su - L_SL;
    end else begin
      su = st + L_SL - R_SL;
    end
    raddr  = AW'({su[SLOT_W-1:0], cc[COL_W-1:0]});
    dy_abs = (ty >= R_TAP) ? ty - R_TAP : R_TAP - ty;
    dx_abs = (tx >= R_TAP) ? tx - R_TAP : R_TAP - tx;
    wy     = weights[dy_abs[DW-1:0]];
    wx     = weights[dx_abs[DW-1:0]];
  end

  assign status.scan_last = (ty == T_LAST) && (tx == T_LAST);
  assign status.pipe_busy = a_v || b_v;
  assign status.div_last  = (dk == 3'd0);

  // Position counters.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_row  <= '0;
      in_slot <= '0;
      in_done <= 1'b0;
      ec      <= '0;
      er      <= '0;
      er_slot <= '0;
    end else if (pixel_acc) begin
      if (in_done) begin
        ec      <= '0;
        er      <= '0;
        er_slot <= '0;
      end
      if (in_col == w_last) begin
        in_col <= '0;
        if (in_row == h_last) begin
          in_row  <= '0;
          in_slot <= '0;
          in_done <= 1'b1;
        end else begin
          in_row  <= in_row + 1'b1;
          in_slot <= (in_slot == S_LAST) ? '0 : in_slot + 1'b1;
          in_done <= 1'b0;
        end
      end else begin
        in_col  <= in_col + 1'b1;
        in_done <= 1'b0;
      end
    end else if (cmd.emit) begin
      if (ec == w_last) begin
        ec <= '0;
        if (er == h_last) begin
          er      <= '0;
          er_slot <= '0;
          in_done <= 1'b0;
        end else begin
          er      <= er + 1'b1;
          er_slot <= (er_slot == S_LAST) ? '0 : er_slot + 1'b1;
        end
      end else begin
        ec <= ec + 1'b1;
      end
    end
  end

  // Scan pipeline: weight product, then pixel product, then accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      ty  <= '0;
      tx  <= '0;
    end else begin
      a_v <= cmd.scan_step;
      b_v <= a_v;
      if (cmd.scan_start) begin
        ty <= '0;
        tx <= '0;
      end else if (cmd.scan_step) begin
        if (tx == T_LAST) begin
          tx <= '0;
          ty <= ty + 1'b1;
        end else begin
          tx <= tx + 1'b1;
        end
      end
    end
  end

  // Drop the memory word of a tap outside the image; it may never have been written.
  always_ff @(posedge clk) begin
    a_ok    <= row_ok && col_ok;
    a_wprod <= (row_ok && col_ok) ? WP_W'(wx) * WP_W'(wy) : '0;
    b_prod  <= a_ok ? (WP_W + 8)'(rdata) * (WP_W + 8)'(a_wprod) : '0;
    if (cmd.scan_start) begin
      wsum <= '0;
      acc  <= '0;
    end else begin
      if (a_v) wsum <= wsum + WS_W'(a_wprod);
      if (b_v) acc  <= acc + ACC_W'(b_prod);
    end
  end

  // Restoring divide, one quotient bit a cycle; quotient never exceeds 255.
  logic [ACC_W-1:0] dvs;
  assign dvs = ACC_W'(wsum) << dk;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= acc;
      dk  <= 3'd7;
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem >= dvs) begin
        rem     <= rem - dvs;
        quo[dk] <= 1'b1;
      end
      dk <= dk - 3'd1;
    end
  end

  always_comb begin
    result.pixel_out  = (wsum == '0) ? 8'd0 : quo;
    result.out_col    = 10'(ec);
    result.out_row    = 10'(er);
    result.frame_last = (ec == w_last) && (er == h_last);
  end

endmodule

// File: src/gaussian_filter_9x9_edge_normalized.sv
// Top level of the streaming 9x9 Gaussian filter with edge normalization.
//
//   channel | signals                         | direction | item
//   in      | in_valid, in_stall, in_data     | in        | pixel or drain tick
//   out     | out_valid, out_stall, out_data  | out       | filtered pixel
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in | register write
//
// An item that completes no output is only taken and checked. For an item that
// completes an output, the window is read from the line store memory one neighbor
// per cycle, then an 8-step divider normalizes the sum. The next item is taken
// while a result waits in the output register. Reset (rst, synchronous) clears
// positions, flags and the registers to their defaults; the line store is not
// cleared.
module gaussian_filter_9x9_edge_normalized
  import gfe_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int RADIUS      = 4,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  gfe_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output gfe_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

  // Configuration registers; writes are always taken.
  logic [10:0]           img_width, img_height;
  logic [NUM_WREG-1:0][15:0] wreg;
  logic                  cfg_we, restart;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && ((cfg_index == REG_IMG_WIDTH) || (cfg_index == REG_IMG_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= 11'd1024;
      img_height <= 11'd1024;
      // Distance 0 weight is full scale, all others zero.
      wreg       <= (NUM_WREG * 16)'(16'hFFFF);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMG_WIDTH:  img_width  <= cfg_data[10:0];
        REG_IMG_HEIGHT: img_height <= cfg_data[10:0];
        REG_WEIGHT_D0:  wreg[0]    <= cfg_data;
        REG_WEIGHT_D1:  wreg[1]    <= cfg_data;
        REG_WEIGHT_D2:  wreg[2]    <= cfg_data;
        REG_WEIGHT_D3:  wreg[3]    <= cfg_data;
        REG_WEIGHT_D4:  wreg[4]    <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Clamp the frame size: zero counts as one, oversize counts as the maximum.
  logic [12:0]       wide_w, wide_h;
  logic [COL_W-1:0]  w_last;
  logic [ROW_W-1:0]  h_last;
  always_comb begin
    wide_w = {2'b00, img_width};
    wide_h = {2'b00, img_height};
    if (wide_w == 13'd0)     w_last = '0;
    else if (wide_w > MAXW)  w_last = COL_W'(MAXW - 13'd1);
    else                     w_last = COL_W'(wide_w - 13'd1);
    if (wide_h == 13'd0)     h_last = '0;
    else if (wide_h > MAXH)  h_last = ROW_W'(MAXH - 13'd1);
    else                     h_last = ROW_W'(wide_h - 13'd1);
  end

  // Keep the top WEIGHT_BITS bits of each weight in use.
  logic [RADIUS:0][WEIGHT_BITS-1:0] weights;
  always_comb begin
    for (int i = 0; i <= RADIUS; i++) begin
      weights[i] = wreg[i][15 -: WEIGHT_BITS];
    end
  end

  gfe_cmd_t    cmd;
  gfe_status_t status;
  gfe_out_t    result;
  logic        out_free;

  // Output register: the next result may load as the current one leaves.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= result;
    end
  end

  gfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .out_free (out_free),
    .cmd      (cmd)
  );

  gfe_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .RADIUS      (RADIUS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .in_data (in_data),
    .restart (restart),
    .w_last  (w_last),
    .h_last  (h_last),
    .weights (weights),
    .status  (status),
    .result  (result)
  );

endmodule

// File: src/gfe_checker.sv
// Port-level checker for the Gaussian filter, bound to the top level.
module gfe_checker
  import gfe_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input gfe_out_t out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // One item at a time: an accepted item stalls the input next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken back to back");

  // A new result only comes out of work on an item.
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule

bind gaussian_filter_9x9_edge_normalized gfe_checker u_gfe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: test/tb.sv
// Self-checking testbench for the streaming 9x9 Gaussian filter with edge normalization.
module tb;
  import gfe_pkg::*;

  localparam int MAXW      = 1024;
  localparam int MAXH      = 1024;
  localparam int RAD       = 4;
  localparam int NLINES    = 2 * RAD + 2;
  localparam int ITEM_GOAL = 850;
  localparam int LIMIT     = 2500000;
  // Latency of one output-producing item, with margin.
  localparam int SETTLE    = 150;

  // Predicts filtered pixels from accepted items and checks the block's results.
  class blur_scoreboard;
    logic [7:0]  rows_mem [NLINES][MAXW];
    int unsigned wid_reg, hgt_reg;
    int unsigned wts [5];
    int unsigned col, row, emitted;
    bit          frame_in;
    gfe_out_t    expected_q [$];
    int          errors, matched, frames;

    function void reset_state();
      wid_reg = 1024;
      hgt_reg = 1024;
      wts[0] = 65535;
      for (int k = 1; k < 5; k++) wts[k] = 0;
      restart();
      expected_q.delete();
    endfunction

    function void restart();
      col = 0;
      row = 0;
      emitted = 0;
      frame_in = 0;
    endfunction

    function int unsigned eff_dim(int unsigned v, int unsigned mx);
      if (v == 0) return 1;
      return (v > mx) ? mx : v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_IMG_WIDTH) begin
        wid_reg = val[10:0];
        restart();
      end else if (idx == REG_IMG_HEIGHT) begin
        hgt_reg = val[10:0];
        restart();
      end else if (idx >= REG_WEIGHT_D0 && idx <= REG_WEIGHT_D4) begin
        wts[idx - REG_WEIGHT_D0] = val;
      end
    endfunction

    // Outputs of a complete frame still waiting for drain ticks.
    function int unsigned frame_left();
      int unsigned tot;
      tot = eff_dim(wid_reg, MAXW) * eff_dim(hgt_reg, MAXH);
      return frame_in ? tot - emitted : 0;
    endfunction

    // Emit the next pixel in raster order if all of its window has arrived.
    function void try_emit();
      int unsigned w, h, tot, er, ec, nr, nc, have;
      longint unsigned acc, wsum, wt, res;
      int r, c;
      gfe_out_t o;
      w = eff_dim(wid_reg, MAXW);
      h = eff_dim(hgt_reg, MAXH);
      tot = w * h;
      if (emitted >= tot) return;
      er = emitted / w;
      ec = emitted % w;
      nr = (er + RAD > h - 1) ? h - 1 : er + RAD;
      nc = (ec + RAD > w - 1) ? w - 1 : ec + RAD;
      have = frame_in ? tot : row * w + col;
      if (nr * w + nc >= have) return;
      acc = 0;
      wsum = 0;
      for (int dy = -RAD; dy <= RAD; dy++) begin
        r = int'(er) + dy;
        if (r < 0 || r >= int'(h)) continue;
        for (int dx = -RAD; dx <= RAD; dx++) begin
          c = int'(ec) + dx;
          if (c < 0 || c >= int'(w)) continue;
          wt = longint'(wts[dx < 0 ? -dx : dx]) * longint'(wts[dy < 0 ? -dy : dy]);
          acc += longint'(rows_mem[r % NLINES][c]) * wt;
          wsum += wt;
        end
      end
      res = (wsum == 0) ? 0 : acc / wsum;
      if (res > 255) res = 255;
      o.pixel_out  = res[7:0];
      o.out_col    = ec[9:0];
      o.out_row    = er[9:0];
      o.frame_last = (emitted == tot - 1);
      expected_q.push_back(o);
      emitted++;
      if (emitted >= tot && frame_in) begin
        emitted = 0;
        frame_in = 0;
        frames++;
      end
    endfunction

    function void note_input(gfe_in_t d);
      int unsigned w, h;
      if (d.cmd == CMD_PIXEL) begin
        w = eff_dim(wid_reg, MAXW);
        h = eff_dim(hgt_reg, MAXH);
        // A pixel after a complete frame drops what is still pending.
        if (frame_in) begin
          emitted = 0;
          frame_in = 0;
        end
        if (col >= w) col = 0;
        rows_mem[row % NLINES][col] = d.pixel_in;
        col++;
        if (col >= w) begin
          col = 0;
          row++;
          if (row >= h) begin
            row = 0;
            frame_in = 1;
          end
        end
      end
      try_emit();
    endfunction

    function void check_result(gfe_out_t got);
      gfe_out_t exp_o;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_o = expected_q.pop_front();
      if (got.pixel_out !== exp_o.pixel_out) begin
        $display("%0t: pixel_out expected %0d actual %0d", $time, exp_o.pixel_out,
                 got.pixel_out);
        errors++;
      end
      if (got.out_col !== exp_o.out_col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, exp_o.out_col, got.out_col);
        errors++;
      end
      if (got.out_row !== exp_o.out_row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, exp_o.out_row, got.out_row);
        errors++;
      end
      if (got.frame_last !== exp_o.frame_last) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, exp_o.frame_last,
                 got.frame_last);
        errors++;
      end
      matched++;
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  gfe_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  gfe_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  blur_scoreboard sb;
  bit             quiet;      // no idling on either side while set
  int             hold_cnt;   // cycles the receiver still holds off
  int             cycles;
  int             items_sent;
  int             cfg_writes;

  gaussian_filter_9x9_edge_normalized uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Bound the run: a hung handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("gaussian_filter_9x9_edge_normalized verification failed");
      $finish;
    end
  end

  // Check every result taken at a rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: stall at random, or hold off for a long stretch on request.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 8);
    end
  end

  // Offer one item; return at the falling edge after it was taken.
  // Valid stays high so a following item is offered without a gap.
  task automatic send_item(gfe_in_t d);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(d);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [7:0] p);
    gfe_in_t d;
    d.cmd = CMD_PIXEL;
    d.pixel_in = p;
    send_item(d);
  endtask

  // Drain ticks carry random junk in the pixel field.
  task automatic send_drain();
    gfe_in_t d;
    d.cmd = CMD_DRAIN;
    d.pixel_in = 8'($urandom);
    send_item(d);
  endtask

  // Flush what the frame still owes, then one tick with nothing pending.
  task automatic flush_frame();
    while (sb.frame_left() > 0) send_drain();
    send_drain();
  endtask

  // Drop valid, wait for every expected result, then let the block go idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
  endtask

  // Program size and all five weights; the block must be idle.
  task automatic load_regs(int unsigned w, int unsigned h, int unsigned w0, int unsigned w1,
                           int unsigned w2, int unsigned w3, int unsigned w4);
    write_reg(REG_IMG_WIDTH, 16'(w));
    write_reg(REG_IMG_HEIGHT, 16'(h));
    write_reg(REG_WEIGHT_D0, 16'(w0));
    write_reg(REG_WEIGHT_D1, 16'(w1));
    write_reg(REG_WEIGHT_D2, 16'(w2));
    write_reg(REG_WEIGHT_D3, 16'(w3));
    write_reg(REG_WEIGHT_D4, 16'(w4));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_pixel();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic int unsigned rand_weight();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 0;
    if (sel == 1) return 65535;
    return $urandom_range(0, 65535);
  endfunction

  function automatic int unsigned rand_dim();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 0;                                  // counts as one
    if (sel == 1) return $urandom_range(1025, 2047);         // oversize, clamped
    if (sel < 4) return $urandom_range(13, 20);
    return $urandom_range(1, 12);
  endfunction

  // Send pixels of the frame; sprinkle drain ticks in as noise.
  task automatic send_pixels(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) send_drain();
      send_pixel(rand_pixel());
    end
  endtask

  initial begin
    int unsigned fw, fh, npix;
    sb = new();
    sb.reset_state();
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMG_WIDTH;
    cfg_data  = '0;
    quiet     = 1'b0;
    hold_cnt  = 0;
    cycles    = 0;
    items_sent = 0;
    cfg_writes = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single-pixel frame from zero size registers, default weights.
    load_regs(0, 0, 65535, 0, 0, 0, 0);
    send_pixel(8'hff);
    send_drain();
    send_pixel(8'h00);
    settle();

    // 3x3 frame, full weights everywhere, extreme pixels.
    load_regs(3, 3, 65535, 65535, 65535, 65535, 65535);
    for (int k = 0; k < 9; k++) send_pixel((k % 2) ? 8'hff : 8'h00);
    flush_frame();
    settle();

    // Zero weight sum gives zero.
    load_regs(2, 2, 0, 0, 0, 0, 0);
    for (int k = 0; k < 4; k++) send_pixel(8'hff);
    flush_frame();
    settle();

    // New frame arrives before the previous one is flushed.
    load_regs(5, 5, 65535, 32768, 16384, 1, 65535);
    send_pixels(25);
    send_pixels(25);
    flush_frame();
    settle();

    // Widest row and tallest column, clamped from the largest register values;
    // the start of each frame only. The receiver holds off at first with no idling.
    quiet = 1'b1;
    hold_cnt = 400;
    load_regs(2047, 1, rand_weight(), rand_weight(), rand_weight(), rand_weight(), 65535);
    send_pixels(150);
    flush_frame();
    settle();
    quiet = 1'b0;
    load_regs(1, 2047, 65535, rand_weight(), rand_weight(), rand_weight(), rand_weight());
    send_pixels(150);
    flush_frame();
    settle();

    // Random frames until enough items have gone through.
    while (items_sent < ITEM_GOAL) begin
      quiet = ($urandom_range(0, 7) == 0);
      fw = rand_dim();
      fh = rand_dim();
      load_regs(fw, fh, rand_weight(), rand_weight(), rand_weight(), rand_weight(),
                rand_weight());
      npix = sb.eff_dim(fw, MAXW) * sb.eff_dim(fh, MAXH);
      // Keep big frames rare.
      if (npix > 60) npix = 60 + $urandom_range(0, 20);
      // Long receiver hold-off while the sender keeps offering items.
      if ($urandom_range(0, 9) == 0) hold_cnt = 400;
      case ($urandom_range(0, 4))
        0: begin
          // Change a weight mid-frame, once the block has caught up.
          send_pixels(npix / 2);
          settle();
          write_reg(REG_WEIGHT_D0 + 3'($urandom_range(0, 4)), 16'(rand_weight()));
          cfg_valid <= 1'b0;
          @(negedge clk);
          send_pixels(npix - npix / 2);
          flush_frame();
        end
        1: begin
          // Abandon a partial frame; the next size write restarts it.
          send_pixels($urandom_range(1, npix));
        end
        2: begin
          // Back-to-back frames without flush in between.
          send_pixels(npix);
          send_pixels(npix);
          flush_frame();
        end
        default: begin
          send_pixels(npix);
          flush_frame();
        end
      endcase
      settle();
    end
    quiet = 1'b0;

    $display("Ran %0d items and %0d register writes; %0d frames completed, %0d results checked.",
             items_sent, cfg_writes, sb.frames, sb.matched);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("gaussian_filter_9x9_edge_normalized verification clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.errors, sb.expected_q.size());
      $display("gaussian_filter_9x9_edge_normalized verification failed");
    end
    $finish;
  end

endmodule
